// File: src/tscm_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tscm_pkg: shared types and constants
// Item formats, register indexes and fixed constants of the channel unit.
// ----------------------------------------------------------------------------
package tscm_pkg;

    localparam int PROB_BITS_DEF  = 32;
    localparam int COUNT_BITS_DEF = 32;
    localparam int REG_CNT        = 8;
    localparam int IDX_BITS       = 3;

    localparam logic [IDX_BITS-1:0] REG_STAY_CLEAR    = 3'd0;
    localparam logic [IDX_BITS-1:0] REG_CLEAR_TO_SHAD = 3'd1;
    localparam logic [IDX_BITS-1:0] REG_SHAD_TO_CLEAR = 3'd2;
    localparam logic [IDX_BITS-1:0] REG_STAY_SHADOW   = 3'd3;
    localparam logic [IDX_BITS-1:0] REG_BLK_TO_CLEAR  = 3'd4;
    localparam logic [IDX_BITS-1:0] REG_STAY_BLOCKED  = 3'd5;
    localparam logic [IDX_BITS-1:0] REG_DISTANCE      = 3'd6;
    localparam logic [IDX_BITS-1:0] REG_SPM           = 3'd7;

    localparam logic [1:0] ST_CLEAR   = 2'd0;
    localparam logic [1:0] ST_SHADOW  = 2'd1;
    localparam logic [1:0] ST_BLOCKED = 2'd2;

    localparam logic [31:0] LN2_Q32 = 32'hB17217F8;

    typedef struct packed {
        logic [31:0] select_uniform;
        logic [31:0] duration_uniform;
    } in_item_t;

    typedef struct packed {
        logic [1:0]  next_state;
        logic [31:0] duration_samples;
        logic        duration_saturated;
    } out_item_t;

endpackage

`default_nettype wire

// File: src/tscm_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tscm_core: sequenced datapath
// One shared 32x32 multiplier, a log squaring loop and a restoring divider.
// ----------------------------------------------------------------------------
module tscm_core
    import tscm_pkg::*;
(
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            start,
    input  wire in_item_t        item,
    input  wire logic [31:0]     cfg [REG_CNT],
    output logic                 done,
    output out_item_t            result
);
    // Fixed 32-bit datapath; widths follow the 32-bit fields.
    localparam logic [3:0] S_IDLE = 4'd0, S_CMP0 = 4'd1, S_CMP1 = 4'd2, S_CMP2 = 4'd3,
                           S_NORM = 4'd4, S_SQ = 4'd5, S_LN0 = 4'd6, S_LN1 = 4'd7,
                           S_P = 4'd8, S_PL0 = 4'd9, S_PL1 = 4'd10, S_PL2 = 4'd11,
                           S_PL3 = 4'd12, S_DIV = 4'd13, S_DONE = 4'd14;

    logic [3:0]   st_reg, st_next;
    logic [1:0]   chan_reg;
    logic [31:0]  u1_reg, u2_reg;
    logic [32:0]  x_reg;
    logic [5:0]   e_reg;
    logic [32:0]  m_reg;
    logic [31:0]  f_reg;
    logic [6:0]   cnt_reg;
    logic [63:0]  acc_reg;
    logic [63:0]  ln_reg;
    logic [63:0]  p_reg;
    logic [127:0] prod_reg;
    logic [32:0]  d_reg;
    logic [32:0]  rem_reg;
    logic [1:0]   ns_reg;

    // shared multiplier
    logic [31:0] ma, mb;
    logic [63:0] mp;
    assign mp = ma * mb;

    logic [31:0] stay_cur, sw, stay_new;
    logic [1:0]  first_st, other_st;
    logic [63:0] l2;

    always_comb
    begin
        case (chan_reg)
            ST_CLEAR:
            begin
                stay_cur = cfg[REG_STAY_CLEAR]; sw = cfg[REG_CLEAR_TO_SHAD];
                first_st = ST_SHADOW; other_st = ST_BLOCKED;
            end
            ST_SHADOW:
            begin
                stay_cur = cfg[REG_STAY_SHADOW]; sw = cfg[REG_SHAD_TO_CLEAR];
                first_st = ST_CLEAR; other_st = ST_BLOCKED;
            end
            default:
            begin
                stay_cur = cfg[REG_STAY_BLOCKED]; sw = cfg[REG_BLK_TO_CLEAR];
                first_st = ST_CLEAR; other_st = ST_SHADOW;
            end
        endcase
        case (ns_reg)
            ST_CLEAR:  stay_new = cfg[REG_STAY_CLEAR];
            ST_SHADOW: stay_new = cfg[REG_STAY_SHADOW];
            default:   stay_new = cfg[REG_STAY_BLOCKED];
        endcase
    end

    assign l2 = {26'd0, 6'd32 - e_reg, 32'd0} - {32'd0, f_reg};

    always_comb
    begin
        ma = 32'd0;
        mb = 32'd0;
        case (st_reg)
            S_CMP0: begin ma = u1_reg; mb = 32'd0 - stay_cur; end
            S_SQ:   begin ma = m_reg[31:0]; mb = m_reg[31:0]; end
            S_LN0:  begin ma = l2[63:32]; mb = LN2_Q32; end
            S_LN1:  begin ma = l2[31:0]; mb = LN2_Q32; end
            S_P:    begin ma = cfg[REG_SPM]; mb = cfg[REG_DISTANCE]; end
            S_PL0:  begin ma = p_reg[31:0];  mb = ln_reg[31:0]; end
            S_PL1:  begin ma = p_reg[31:0];  mb = ln_reg[63:32]; end
            S_PL2:  begin ma = p_reg[63:32]; mb = ln_reg[31:0]; end
            S_PL3:  begin ma = p_reg[63:32]; mb = ln_reg[63:32]; end
            default: ;
        endcase
    end

    // priority encoder for x (33 bits)
    logic [5:0] top_bit;
    always_comb
    begin
        top_bit = 6'd0;
        for (int i = 0; i <= 32; i++)
            if (x_reg[i]) top_bit = 6'(i);
    end

    logic [63:0] sq_sh;
    assign sq_sh = mp >> 31;

    logic [33:0] rem_sh, rem_sub;
    assign rem_sh  = {rem_reg, prod_reg[127]};
    assign rem_sub = rem_sh - {1'b0, d_reg};

    always_comb
    begin
        st_next = st_reg;
        case (st_reg)
            S_IDLE:  if (start) st_next = S_CMP0;
            S_CMP0:  st_next = S_CMP1;
            S_CMP1:  st_next = S_CMP2;
            S_CMP2:  st_next = S_NORM;
            S_NORM:  st_next = S_SQ;
            S_SQ:    if (cnt_reg == 7'd31) st_next = S_LN0;
            S_LN0:   st_next = S_LN1;
            S_LN1:   st_next = S_P;
            S_P:     st_next = S_PL0;
            S_PL0:   st_next = S_PL1;
            S_PL1:   st_next = S_PL2;
            S_PL2:   st_next = S_PL3;
            S_PL3:   st_next = S_DIV;
            S_DIV:   if (cnt_reg == 7'd127) st_next = S_DONE;
            S_DONE:  st_next = S_IDLE;
            default: st_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg   <= S_IDLE;
            chan_reg <= ST_CLEAR;
        end
        else
        begin
            st_reg <= st_next;
            if (st_reg == S_DONE) chan_reg <= ns_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        case (st_reg)
            S_IDLE:
            begin
                u1_reg  <= item.select_uniform;
                u2_reg  <= item.duration_uniform;
                cnt_reg <= 7'd0;
            end
            S_CMP0:
            begin
                // u*(2^32 - stay) = u*(0 - stay) + (stay==0 ? u<<32 : 0)
                acc_reg <= mp;
                x_reg   <= 33'h1_0000_0000 - {1'b0, u2_reg};
            end
            S_CMP1:
            begin
                // compare {hi,lo} against sw<<32
                if (stay_cur == 32'd0)
                    ns_reg <= (u1_reg <= sw) ? first_st : other_st;
                else
                    ns_reg <= (acc_reg <= {sw, 32'd0}) ? first_st : other_st;
                e_reg <= top_bit;
            end
            S_CMP2:
            begin
                d_reg <= 33'h1_0000_0000 - {1'b0, stay_new};
            end
            S_NORM:
            begin
                if (e_reg >= 6'd31) m_reg <= x_reg >> (e_reg - 6'd31);
                else                m_reg <= x_reg << (6'd31 - e_reg);
                f_reg   <= 32'd0;
                cnt_reg <= 7'd0;
            end
            S_SQ:
            begin
                if (sq_sh[32])
                begin
                    m_reg <= sq_sh[33:1];
                    f_reg <= {f_reg[30:0], 1'b1};
                end
                else
                begin
                    m_reg <= sq_sh[32:0];
                    f_reg <= {f_reg[30:0], 1'b0};
                end
                cnt_reg <= cnt_reg + 7'd1;
            end
            S_LN0: ln_reg <= mp;
            S_LN1: ln_reg <= ln_reg + {32'd0, mp[63:32]};
            S_P:
            begin
                p_reg    <= mp;
                prod_reg <= '0;
            end
            S_PL0: prod_reg <= prod_reg + {64'd0, mp};
            S_PL1: prod_reg <= prod_reg + {32'd0, mp, 32'd0};
            S_PL2: prod_reg <= prod_reg + {32'd0, mp, 32'd0};
            S_PL3:
            begin
                // add the product's top word and the rounding half d<<31
                prod_reg <= prod_reg + {mp, 64'd0} + {64'd0, d_reg[32:0], 31'd0};
                rem_reg  <= '0;
                cnt_reg  <= 7'd0;
            end
            S_DIV:
            begin
                if (rem_sh >= {1'b0, d_reg})
                begin
                    rem_reg  <= rem_sub[32:0];
                    prod_reg <= {prod_reg[126:0], 1'b1};
                end
                else
                begin
                    rem_reg  <= rem_sh[32:0];
                    prod_reg <= {prod_reg[126:0], 1'b0};
                end
                cnt_reg <= cnt_reg + 7'd1;
            end
            default: ;
        endcase
    end

    // quotient q in prod_reg; count = q >> 32
    logic sat;
    assign sat = (prod_reg[127:64] != 64'd0);

    assign done = (st_reg == S_DONE);
    always_comb
    begin
        result.next_state         = ns_reg;
        result.duration_saturated = sat;
        result.duration_samples   = sat ? 32'hFFFF_FFFF : prod_reg[63:32];
    end

endmodule

`default_nettype wire

// File: src/three_state_channel_markov_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// three_state_channel_markov_unit: channel state chain
// Picks the next clear/shadowed/blocked state and its stay length per item.
// ----------------------------------------------------------------------------
// Each item passes from acceptance to out_valid through 4 setup steps, 32
// squaring steps of the log on the shared 32x32 multiplier, 7 multiply steps
// and a 128-step restoring division; S_DONE then hands off the result.
// in_stall is high from acceptance until the result has been taken, so the
// unit holds one item at a time; the result waits in an output register.
module three_state_channel_markov_unit
    import tscm_pkg::*;
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    output logic                     in_stall,
    input  wire in_item_t            in_data,
    output logic                     out_valid,
    input  wire logic                out_stall,
    output out_item_t                out_data,
    input  wire logic                cfg_we,
    input  wire logic [IDX_BITS-1:0] cfg_index,
    input  wire logic [31:0]         cfg_data
);
    logic [31:0] cfg_reg [REG_CNT];
    logic        busy_reg, ov_reg, done;
    out_item_t   res, out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg[REG_STAY_CLEAR]    <= 32'd0;
            cfg_reg[REG_CLEAR_TO_SHAD] <= 32'd0;
            cfg_reg[REG_SHAD_TO_CLEAR] <= 32'd0;
            cfg_reg[REG_STAY_SHADOW]   <= 32'd0;
            cfg_reg[REG_BLK_TO_CLEAR]  <= 32'd0;
            cfg_reg[REG_STAY_BLOCKED]  <= 32'd0;
            cfg_reg[REG_DISTANCE]      <= 32'h0001_0000;
            cfg_reg[REG_SPM]           <= 32'h0001_0000;
        end
        else if (cfg_we)
            cfg_reg[cfg_index] <= cfg_data;
    end

    assign in_stall = busy_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            ov_reg   <= 1'b0;
        end
        else
        begin
            if (in_valid && !busy_reg) busy_reg <= 1'b1;
            if (done) ov_reg <= 1'b1;
            else if (ov_reg && !out_stall)
            begin
                ov_reg   <= 1'b0;
                busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
        if (done) out_reg <= res;

    assign out_valid = ov_reg;
    assign out_data  = out_reg;

    tscm_core u_core
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (in_valid && !busy_reg),
        .item   (in_data),
        .cfg    (cfg_reg),
        .done   (done),
        .result (res)
    );

endmodule

`default_nettype wire
